// ===== hw/rtl/rgb_to_nv12_block_converter_macros.svh =====
// Assertion helpers shared by the converter RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef RGB_TO_NV12_BLOCK_CONVERTER_MACROS_SVH
`define RGB_TO_NV12_BLOCK_CONVERTER_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define R2NV_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("converter check failed");

// The condition must hold in the cycle after the trigger.
`define R2NV_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("converter check failed");

`endif

// ===== hw/rtl/r2nv_pkg.sv =====
`default_nettype none
package r2nv_pkg;

  // Per-pixel result of one lane.
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
  } r2nv_lane_t;

  localparam int unsigned NumLanes = 4;

  // BT.601 studio-range coefficients.
  localparam logic [15:0] Y_R   = 16'd66;
  localparam logic [15:0] Y_G   = 16'd129;
  localparam logic [15:0] Y_B   = 16'd25;
  localparam logic [15:0] CB_R  = 16'd38;
  localparam logic [15:0] CB_G  = 16'd74;
  localparam logic [15:0] C_MAX = 16'd112;
  localparam logic [15:0] CR_G  = 16'd94;
  localparam logic [15:0] CR_B  = 16'd18;

  // Rounding term, and rounding plus the 128 offset pre-shifted by 8.
  localparam logic [15:0] ROUND      = 16'd128;
  localparam logic [15:0] ROUND_BIAS = 16'd32896;
  localparam logic [7:0]  LUMA_OFS   = 8'd16;
  localparam logic [9:0]  AVG_ROUND  = 10'd2;

  // Output ranges implied by the matrix.
  localparam logic [7:0] LUMA_MIN   = 8'd16;
  localparam logic [7:0] LUMA_MAX   = 8'd235;
  localparam logic [7:0] CHROMA_MIN = 8'd16;
  localparam logic [7:0] CHROMA_MAX = 8'd240;

endpackage
`default_nettype wire

// ===== hw/rtl/r2nv_lane.sv =====
`default_nettype none
module r2nv_lane import r2nv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [23:0] pix,
  output r2nv_lane_t       lane_q
);

  logic [15:0] r16, g16, b16;
  logic [15:0] y_sum, cb_pos, cb_neg, cb_sum, cr_pos, cr_neg, cr_sum;
  r2nv_lane_t  lane_r, lane_nxt;

  assign r16 = {8'd0, pix[7:0]};
  assign g16 = {8'd0, pix[15:8]};
  assign b16 = {8'd0, pix[23:16]};

  // All sums stay within 16 bits and the chroma differences stay positive
  // thanks to the 128*256 bias, so the shift by 8 is a plain byte select.
  always_comb begin
    y_sum  = r16 * Y_R + g16 * Y_G + b16 * Y_B + ROUND;
    cb_pos = b16 * C_MAX + ROUND_BIAS;
    cb_neg = r16 * CB_R + g16 * CB_G;
    cb_sum = cb_pos - cb_neg;
    cr_pos = r16 * C_MAX + ROUND_BIAS;
    cr_neg = g16 * CR_G + b16 * CR_B;
    cr_sum = cr_pos - cr_neg;
    lane_nxt.luma = y_sum[15:8] + LUMA_OFS;
    lane_nxt.cb   = cb_sum[15:8];
    lane_nxt.cr   = cr_sum[15:8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_q = lane_r;

endmodule
`default_nettype wire

// ===== hw/rtl/r2nv_merge.sv =====
`default_nettype none
module r2nv_merge import r2nv_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire r2nv_lane_t [NumLanes-1:0] lanes,
  output logic [7:0]                     luma_tl,
  output logic [7:0]                     luma_tr,
  output logic [7:0]                     luma_bl,
  output logic [7:0]                     luma_br,
  output logic [7:0]                     cb,
  output logic [7:0]                     cr
);

  logic [9:0] cb_sum, cr_sum;
  logic [7:0] luma_tl_r, luma_tr_r, luma_bl_r, luma_br_r, cb_r, cr_r;

  // Each per-pixel chroma lies in 16..240, so the rounded quarter of the
  // sum never leaves that range and needs no clamp.
  always_comb begin
    cb_sum = {2'd0, lanes[0].cb} + {2'd0, lanes[1].cb} + {2'd0, lanes[2].cb}
           + {2'd0, lanes[3].cb} + AVG_ROUND;
    cr_sum = {2'd0, lanes[0].cr} + {2'd0, lanes[1].cr} + {2'd0, lanes[2].cr}
           + {2'd0, lanes[3].cr} + AVG_ROUND;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      luma_tl_r <= lanes[0].luma;
      luma_tr_r <= lanes[1].luma;
      luma_bl_r <= lanes[2].luma;
      luma_br_r <= lanes[3].luma;
      cb_r      <= cb_sum[9:2];
      cr_r      <= cr_sum[9:2];
    end
  end

  assign luma_tl = luma_tl_r;
  assign luma_tr = luma_tr_r;
  assign luma_bl = luma_bl_r;
  assign luma_br = luma_br_r;
  assign cb      = cb_r;
  assign cr      = cr_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rgb_to_nv12_block_converter.sv =====
// RGB to NV12 2x2 block converter, BT.601 studio range.
// Input channel: in_valid/in_ready carry one item, a 2x2 block of RGB pixels
// (red in bits 7:0, green 15:8, blue 23:16) plus has_right and has_bottom.
// When has_right is low the left pixel of each row replaces the right one;
// when has_bottom is low the top row replaces the bottom row.
// Output channel: out_valid/out_ready carry one item per input item, four
// luma bytes and one averaged Cb/Cr pair.
// The pipeline has two register stages: an item accepted at a rising edge is
// converted by the four pixel lanes, which compute luma and chroma, and held in
// their registers; once the output register can load, the merge stage sums the
// chroma and loads the output register, which raises out_valid.
// Throughput is one item per cycle while out_ready stays high; each stage refills
// whenever the stage after it empties or is being drained in the same cycle.
// When the receiver stalls, the output register holds its item and the
// lane stage can still take one more item before in_ready drops.
// Reset (rst_n low, synchronous) empties both stages; any item held at that
// time is dropped, and no item is invented since nothing is held afterward.
`default_nettype none
`include "rgb_to_nv12_block_converter_macros.svh"
module rgb_to_nv12_block_converter import r2nv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] in_pixel_top_left,
  input  wire logic [23:0] in_pixel_top_right,
  input  wire logic [23:0] in_pixel_bottom_left,
  input  wire logic [23:0] in_pixel_bottom_right,
  input  wire logic        in_has_right,
  input  wire logic        in_has_bottom,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_luma_top_left,
  output logic [7:0]       out_luma_top_right,
  output logic [7:0]       out_luma_bottom_left,
  output logic [7:0]       out_luma_bottom_right,
  output logic [7:0]       out_chroma_blue,
  output logic [7:0]       out_chroma_red
);

  logic                      lane_en, merge_en;
  logic                      v1_r, v1_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [23:0]               px_tr, px_bl, px_br, row_br;
  r2nv_lane_t [NumLanes-1:0] lanes;
  logic                      luma_ok, chroma_ok;

  // The output register may load when it is empty or being drained; the
  // lane stage may load when it is empty or moving into the output.
  assign merge_en = !out_valid_r || out_ready;
  assign lane_en  = !v1_r || merge_en;
  assign in_ready = lane_en;

  always_comb begin
    v1_nxt        = lane_en ? in_valid : v1_r;
    out_valid_nxt = merge_en ? v1_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Edge replication: right column first, then the bottom row copies the
  // top row as it stands after that.
  always_comb begin
    px_tr  = in_has_right ? in_pixel_top_right : in_pixel_top_left;
    row_br = in_has_right ? in_pixel_bottom_right : in_pixel_bottom_left;
    px_bl  = in_has_bottom ? in_pixel_bottom_left : in_pixel_top_left;
    px_br  = in_has_bottom ? row_br : px_tr;
  end

  r2nv_lane u_lane_tl (
    .clk    (clk),
    .en     (lane_en && in_valid),
    .pix    (in_pixel_top_left),
    .lane_q (lanes[0])
  );

  r2nv_lane u_lane_tr (
    .clk    (clk),
    .en     (lane_en && in_valid),
    .pix    (px_tr),
    .lane_q (lanes[1])
  );

  r2nv_lane u_lane_bl (
    .clk    (clk),
    .en     (lane_en && in_valid),
    .pix    (px_bl),
    .lane_q (lanes[2])
  );

  r2nv_lane u_lane_br (
    .clk    (clk),
    .en     (lane_en && in_valid),
    .pix    (px_br),
    .lane_q (lanes[3])
  );

  r2nv_merge u_merge (
    .clk     (clk),
    .en      (merge_en && v1_r),
    .lanes   (lanes),
    .luma_tl (out_luma_top_left),
    .luma_tr (out_luma_top_right),
    .luma_bl (out_luma_bottom_left),
    .luma_br (out_luma_bottom_right),
    .cb      (out_chroma_blue),
    .cr      (out_chroma_red)
  );

  // Range checks: the matrix confines luma and chroma to studio range.
  assign luma_ok =
      out_luma_top_left >= LUMA_MIN && out_luma_top_left <= LUMA_MAX &&
      out_luma_top_right >= LUMA_MIN && out_luma_top_right <= LUMA_MAX &&
      out_luma_bottom_left >= LUMA_MIN && out_luma_bottom_left <= LUMA_MAX &&
      out_luma_bottom_right >= LUMA_MIN && out_luma_bottom_right <= LUMA_MAX;
  assign chroma_ok =
      out_chroma_blue >= CHROMA_MIN && out_chroma_blue <= CHROMA_MAX &&
      out_chroma_red >= CHROMA_MIN && out_chroma_red <= CHROMA_MAX;

  `R2NV_ASSERT_NEXT(a_accept_fills_lanes, in_valid && in_ready, v1_r)
  `R2NV_ASSERT_NEXT(a_stall_keeps_lanes, v1_r && !merge_en, v1_r)
  `R2NV_ASSERT_NEXT(a_lanes_feed_output, v1_r && merge_en, out_valid_r)
  `R2NV_ASSERT_SAME(a_luma_range, out_valid_r, luma_ok)
  `R2NV_ASSERT_SAME(a_chroma_range, out_valid_r, chroma_ok)

endmodule
`default_nettype wire

// ===== tb/tb_rgb_to_nv12_block_converter.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the 2x2 RGB to NV12 block converter.
// A sender process pushes 2x2 RGB blocks into the input channel and a receiver
// process drains the output channel. Both sides insert random idle cycles.
// Every accepted block is run through a BT.601 predictor in the scoreboard.
// Every accepted result is compared field by field against the oldest
// prediction still waiting.
module tb_rgb_to_nv12_block_converter;

  // Longest run of cycles without any handshake before the run is declared hung.
  // A correct run never idles longer than one sender gap plus one receiver
  // stall plus the trip through the pipeline, so this is many times the worst case.
  localparam int IdleLimit    = 400;
  localparam int RandomBlocks = 1430;
  // Cycles to linger after the last result, so late or extra results show up.
  localparam int DrainCycles  = 8;
  localparam int MaxIdle      = 14;

  // One input item: four packed RGB pixels (red 7:0, green 15:8, blue 23:16)
  // and the edge flags has_right and has_bottom.
  typedef struct packed {
    logic [23:0] top_left;
    logic [23:0] top_right;
    logic [23:0] bottom_left;
    logic [23:0] bottom_right;
    logic        has_right;
    logic        has_bottom;
  } rgb_block_t;

  // One result item, in output port order. Field k sits at bits 47-8k down.
  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } nv12_block_t;

  // Scoreboard: predicts each block's NV12 bytes and holds them in order.
  class nv12_scoreboard;
    nv12_block_t expected_q[$];
    int          error_count;
    string       field_names[6];

    function new();
      error_count = 0;
      field_names = '{"luma_top_left", "luma_top_right", "luma_bottom_left",
                      "luma_bottom_right", "chroma_blue", "chroma_red"};
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
    endtask

    function logic [7:0] clamp_byte(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    // Integer BT.601 studio-range matrix. The chroma terms carry the +128 offset
    // pre-shifted into the rounding constant, so the per-pixel values stay
    // positive, so the rounded average over four pixels can use plain division.
    function nv12_block_t convert(rgb_block_t blk);
      logic [23:0] px[4];
      logic [7:0]  luma[4];
      int          r, g, b, cb_sum, cr_sum;
      nv12_block_t res;
      px[0] = blk.top_left;
      px[1] = blk.top_right;
      px[2] = blk.bottom_left;
      px[3] = blk.bottom_right;
      // Right column outside the image: each row reuses its left pixel.
      if (!blk.has_right) begin
        px[1] = px[0];
        px[3] = px[2];
      end
      // Bottom row outside the image: the (possibly replicated) top row stands in.
      if (!blk.has_bottom) begin
        px[2] = px[0];
        px[3] = px[1];
      end
      cb_sum = 0;
      cr_sum = 0;
      for (int k = 0; k < 4; k++) begin
        r = int'(px[k][7:0]);
        g = int'(px[k][15:8]);
        b = int'(px[k][23:16]);
        luma[k] = clamp_byte(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
        cb_sum += (112 * b - 38 * r - 74 * g + 128 + 32768) >>> 8;
        cr_sum += (112 * r - 94 * g - 18 * b + 128 + 32768) >>> 8;
      end
      res.luma_top_left     = luma[0];
      res.luma_top_right    = luma[1];
      res.luma_bottom_left  = luma[2];
      res.luma_bottom_right = luma[3];
      res.chroma_blue       = clamp_byte((cb_sum + 2) / 4);
      res.chroma_red        = clamp_byte((cr_sum + 2) / 4);
      return res;
    endfunction

    function void note_block(rgb_block_t blk);
      expected_q = {expected_q, convert(blk)};
    endfunction

    task check_result(nv12_block_t got);
      nv12_block_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h arrived with nothing outstanding", got));
        return;
      end
      want = expected_q.pop_front();
      for (int k = 0; k < 6; k++) begin
        if (got[47 - 8 * k -: 8] !== want[47 - 8 * k -: 8]) begin
          report($sformatf("%s got %h, predicted %h", field_names[k],
                           got[47 - 8 * k -: 8], want[47 - 8 * k -: 8]));
        end
      end
    endtask

    task flush_leftover();
      while (expected_q.size() != 0) begin
        report($sformatf("predicted result %h never arrived", expected_q.pop_front()));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // All inputs start at known values. After that they only change through
  // nonblocking assignments at the rising edge.
  logic        clk                   = 1'b0;
  logic        rst_n                 = 1'b0;
  logic        in_valid              = 1'b0;
  logic [23:0] in_pixel_top_left     = '0;
  logic [23:0] in_pixel_top_right    = '0;
  logic [23:0] in_pixel_bottom_left  = '0;
  logic [23:0] in_pixel_bottom_right = '0;
  logic        in_has_right          = 1'b0;
  logic        in_has_bottom         = 1'b0;
  logic        out_ready             = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_luma_top_left;
  logic [7:0]  out_luma_top_right;
  logic [7:0]  out_luma_bottom_left;
  logic [7:0]  out_luma_bottom_right;
  logic [7:0]  out_chroma_blue;
  logic [7:0]  out_chroma_red;

  nv12_scoreboard sb = new();

  // While a side is in a burst it never idles. Burst mode is redrawn every 50
  // items, on one time in three, so back-to-back and ragged traffic get exercised.
  bit in_burst     = 1'b0;
  bit out_burst    = 1'b0;
  int blocks_sent  = 0;
  int results_seen = 0;
  int idle_cycles  = 0;

  rgb_block_t directed_q[$];

  rgb_to_nv12_block_converter dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_pixel_top_left    (in_pixel_top_left),
    .in_pixel_top_right   (in_pixel_top_right),
    .in_pixel_bottom_left (in_pixel_bottom_left),
    .in_pixel_bottom_right(in_pixel_bottom_right),
    .in_has_right         (in_has_right),
    .in_has_bottom        (in_has_bottom),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_luma_top_left    (out_luma_top_left),
    .out_luma_top_right   (out_luma_top_right),
    .out_luma_bottom_left (out_luma_bottom_left),
    .out_luma_bottom_right(out_luma_bottom_right),
    .out_chroma_blue      (out_chroma_blue),
    .out_chroma_red       (out_chroma_red)
  );

  always #10 clk = ~clk;

  function rgb_block_t make_block(logic [23:0] tl, logic [23:0] tr, logic [23:0] bl,
                                  logic [23:0] br, logic hr, logic hb);
    rgb_block_t blk;
    blk.top_left     = tl;
    blk.top_right    = tr;
    blk.bottom_left  = bl;
    blk.bottom_right = br;
    blk.has_right    = hr;
    blk.has_bottom   = hb;
    return blk;
  endfunction

  // Appends one block to the directed list.
  function void add_directed(rgb_block_t blk);
    directed_q = {directed_q, blk};
  endfunction

  // Half of the pixels are uniformly random. The rest build each channel from
  // 0, 255 or a random byte, so saturated colors and the chroma extremes come
  // up often.
  function logic [23:0] random_pixel();
    logic [23:0] px;
    if ($urandom_range(0, 1) == 0) begin
      px = 24'($urandom_range(0, 24'hFFFFFF));
    end else begin
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(0, 2))
          0: px[8 * c +: 8] = 8'h00;
          1: px[8 * c +: 8] = 8'hFF;
          default: px[8 * c +: 8] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    return px;
  endfunction

  // Blocks at the image edges are rarer than interior ones, as in a real frame.
  // Each flag is still low about a quarter of the time.
  function rgb_block_t random_block();
    return make_block(random_pixel(), random_pixel(), random_pixel(), random_pixel(),
                      $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
  endfunction

  // Present one item on the input channel and hold it until it is accepted.
  // A zero gap keeps in_valid high straight into the next item. That way
  // in_valid never gets two assignments in the same time step.
  task send_block(rgb_block_t blk);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_pixel_top_left     <= blk.top_left;
    in_pixel_top_right    <= blk.top_right;
    in_pixel_bottom_left  <= blk.bottom_left;
    in_pixel_bottom_right <= blk.bottom_right;
    in_has_right          <= blk.has_right;
    in_has_bottom         <= blk.has_bottom;
    // Signals read right after the edge still hold their pre-edge values,
    // which is exactly what the block saw when it decided on acceptance.
    do @(posedge clk); while (!in_ready);
    sb.note_block(blk);
    blocks_sent++;
    if (blocks_sent % 50 == 0) in_burst = ($urandom_range(0, 2) == 0);
  endtask

  // Drain the output channel forever. Before each item, out_ready is held low
  // for a random stall.
  task receive_results();
    int stall;
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, MaxIdle);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result({out_luma_top_left, out_luma_top_right, out_luma_bottom_left,
                       out_luma_bottom_right, out_chroma_blue, out_chroma_red});
      results_seen++;
      if (results_seen % 50 == 0) out_burst = ($urandom_range(0, 2) == 0);
    end
  endtask

  // Watchdog. Any handshake on either channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    // Directed blocks: black and white, the primaries, every combination of
    // the edge flags with junk in the pixels that are supposed to be replaced,
    // the colors that push Cb and Cr to their extremes, and alternating bit
    // patterns.
    add_directed(make_block(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b1));
    add_directed(make_block(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1));
    for (int f = 0; f < 4; f++) begin
      add_directed(make_block(24'h0000FF, 24'h00FF00, 24'hFF0000, 24'hFFFFFF,
                              f[0], f[1]));
    end
    add_directed(make_block(24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b0));
    add_directed(make_block(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0));
    add_directed(make_block(24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b0, 1'b1));
    add_directed(make_block(24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0));
    add_directed(make_block(24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000, 1'b1, 1'b1));
    add_directed(make_block(24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h0000FF, 1'b1, 1'b1));
    add_directed(make_block(24'h00FF00, 24'h00FF00, 24'h00FF00, 24'h00FF00, 1'b1, 1'b1));
    add_directed(make_block(24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 1'b1, 1'b1));
    add_directed(make_block(24'hFFFF00, 24'hFFFF00, 24'hFFFF00, 24'hFFFF00, 1'b1, 1'b1));
    add_directed(make_block(24'hFF00FF, 24'hFF00FF, 24'hFF00FF, 24'hFF00FF, 1'b1, 1'b1));
    add_directed(make_block(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 1'b1, 1'b1));
    add_directed(make_block(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 1'b0, 1'b1));
    add_directed(make_block(24'h0000FF, 24'hFF0000, 24'h00FF00, 24'h000000, 1'b1, 1'b0));
    add_directed(make_block(24'h010101, 24'hFEFEFE, 24'h808080, 24'h7F7F7F, 1'b1, 1'b1));

    // Synchronous reset, held from time zero and never asserted again.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    fork
      receive_results();
    join_none

    foreach (directed_q[i]) send_block(directed_q[i]);
    repeat (RandomBlocks) send_block(random_block());
    in_valid <= 1'b0;

    // Wait for the pipeline to deliver everything predicted. The watchdog
    // bounds this wait. Then linger a little to catch stray results.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    sb.flush_leftover();

    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/r2nv_pkg.sv
hw/rtl/r2nv_lane.sv
hw/rtl/r2nv_merge.sv
hw/rtl/rgb_to_nv12_block_converter.sv
tb/tb_rgb_to_nv12_block_converter.sv
